// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the owner access table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OAT_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("owner access table: implication check failed");
`define OAT_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("owner access table: next-cycle check failed");
`define OAT_ASSERT_ALW(label, clk, rst, c) \
  label: assert property (@(posedge clk) disable iff (rst) (c)) \
    else $error("owner access table: invariant check failed");
`else
`define OAT_ASSERT_IMP(label, clk, rst, a, c)
`define OAT_ASSERT_NXT(label, clk, rst, a, c)
`define OAT_ASSERT_ALW(label, clk, rst, c)
`endif
`endif

// ----- rtl/core/oat_pkg.sv -----
// Package with types and constants of the owner access table.
package oat_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int DEFAULT_OWNER_COUNT = 4;

  localparam int KEY_W    = 64;
  localparam int REQ_W    = 2;
  localparam int OWNER_W  = 3;
  localparam int STATUS_W = 3;

  localparam logic [KEY_W-1:0] SPOOL_UPPER = 64'hba8d_1643_50b6_49cc;
  localparam logic [KEY_W-1:0] SPOOL_LOWER = 64'h861d_2c01_bed1_4be8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CHECK  = 2'd2,
    REQ_NOP    = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DENIED    = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Lookup result that travels along the chain of entry cells.
  typedef struct packed {
    logic hit;
    logic hit_same;
    logic hit_open;
    logic free_found;
  } chain_flags_t;

  // Table update broadcast to all cells at the end of a transaction.
  typedef struct packed {
    logic set;
    logic clr;
  } wr_cmd_t;

endpackage

// ----- rtl/core/oat_cell.sv -----
// One table entry together with its stage of the lookup chain.
module oat_cell #(
  parameter int CellIndex   = 0,
  parameter int OwnerCount  = oat_pkg::DEFAULT_OWNER_COUNT,
  parameter int IdxWidth    = 4,
  parameter int HolderWidth = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [oat_pkg::KEY_W-1:0]     key_upper,
  input  logic [oat_pkg::KEY_W-1:0]     key_lower,
  input  logic [oat_pkg::OWNER_W-1:0]   requester,
  input  oat_pkg::wr_cmd_t              wr_cmd,
  input  logic [IdxWidth-1:0]           wr_idx,
  input  logic                          in_vld,
  input  oat_pkg::chain_flags_t         in_flags,
  input  logic [IdxWidth-1:0]           in_hit_idx,
  input  logic [IdxWidth-1:0]           in_free_idx,
  output logic                          out_vld,
  output oat_pkg::chain_flags_t         out_flags,
  output logic [IdxWidth-1:0]           out_hit_idx,
  output logic [IdxWidth-1:0]           out_free_idx
);
  import oat_pkg::*;

  localparam logic [IdxWidth-1:0] MyIdx = IdxWidth'(CellIndex);

  logic                   valid;
  logic [KEY_W-1:0]       ent_upper;
  logic [KEY_W-1:0]       ent_lower;
  logic [HolderWidth-1:0] holder;

  logic                   match;
  chain_flags_t           flags_next;
  logic [IdxWidth-1:0]    hit_idx_next;
  logic [IdxWidth-1:0]    free_idx_next;
  logic                   sel;

  assign sel   = (wr_idx == MyIdx);
  assign match = valid && (ent_upper == key_upper) && (ent_lower == key_lower);

  always_comb begin
    flags_next    = in_flags;
    hit_idx_next  = in_hit_idx;
    free_idx_next = in_free_idx;
    if (!in_flags.hit && match) begin
      flags_next.hit      = 1'b1;
      flags_next.hit_same = (holder == HolderWidth'(requester));
      flags_next.hit_open = (holder == HolderWidth'(OwnerCount));
      hit_idx_next        = MyIdx;
    end
    if (!in_flags.free_found && !valid) begin
      flags_next.free_found = 1'b1;
      free_idx_next         = MyIdx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= (CellIndex == 0);
      ent_upper <= SPOOL_UPPER;
      ent_lower <= SPOOL_LOWER;
      holder    <= HolderWidth'(OwnerCount);
      out_vld   <= 1'b0;
    end else begin
      out_vld <= in_vld;
      if (wr_cmd.set && sel) begin
        valid     <= 1'b1;
        ent_upper <= key_upper;
        ent_lower <= key_lower;
        holder    <= HolderWidth'(requester);
      end else if (wr_cmd.clr && sel) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_flags    <= flags_next;
    out_hit_idx  <= hit_idx_next;
    out_free_idx <= free_idx_next;
  end

endmodule

// ----- rtl/core/owner_access_table_core.sv -----
// Top level of the owner access table: request control and the chain of entry cells.
// done and the status are registered once the lookup token leaves the last cell.
// One transaction at a time: the lookup token walks the cell chain one entry per
// cycle, and busy stays high until the status strobe.
// Reset clears all entries but entry 0, which holds the spooler id as free-for-all.
// The status is shown for one cycle with done; the receiver cannot stall it.
module owner_access_table_core #(
  parameter int TableDepth = oat_pkg::DEFAULT_TABLE_DEPTH,
  parameter int OwnerCount = oat_pkg::DEFAULT_OWNER_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [oat_pkg::REQ_W-1:0]     req_type,
  input  logic [oat_pkg::KEY_W-1:0]     key_upper,
  input  logic [oat_pkg::KEY_W-1:0]     key_lower,
  input  logic [oat_pkg::OWNER_W-1:0]   requester,
  output logic                          done,
  output logic [oat_pkg::STATUS_W-1:0]  status
);
  import oat_pkg::*;
  `include "assert_macros.svh"

  localparam int IdxWidth    = $clog2(TableDepth);
  localparam int HolderWidth = (OwnerCount > 7) ? 4 : 3;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t              state;
  logic                launch;
  logic [REQ_W-1:0]    req_kind;
  logic [KEY_W-1:0]    req_upper;
  logic [KEY_W-1:0]    req_lower;
  logic [OWNER_W-1:0]  req_owner;

  logic                chain_vld      [TableDepth+1];
  chain_flags_t        chain_flags    [TableDepth+1];
  logic [IdxWidth-1:0] chain_hit_idx  [TableDepth+1];
  logic [IdxWidth-1:0] chain_free_idx [TableDepth+1];
  logic [TableDepth:0] vld_vec;

  chain_flags_t        fin;
  logic                fin_vld;
  wr_cmd_t             wr_cmd;
  logic [IdxWidth-1:0] wr_idx;
  status_t             status_next;

  assign chain_vld[0]      = launch;
  assign chain_flags[0]    = '0;
  assign chain_hit_idx[0]  = '0;
  assign chain_free_idx[0] = '0;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    oat_cell #(
      .CellIndex  (i),
      .OwnerCount (OwnerCount),
      .IdxWidth   (IdxWidth),
      .HolderWidth(HolderWidth)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .key_upper   (req_upper),
      .key_lower   (req_lower),
      .requester   (req_owner),
      .wr_cmd      (wr_cmd),
      .wr_idx      (wr_idx),
      .in_vld      (chain_vld[i]),
      .in_flags    (chain_flags[i]),
      .in_hit_idx  (chain_hit_idx[i]),
      .in_free_idx (chain_free_idx[i]),
      .out_vld     (chain_vld[i+1]),
      .out_flags   (chain_flags[i+1]),
      .out_hit_idx (chain_hit_idx[i+1]),
      .out_free_idx(chain_free_idx[i+1])
    );
  end

  always_comb begin
    for (int i = 0; i <= TableDepth; i++) begin
      vld_vec[i] = chain_vld[i];
    end
  end

  assign fin     = chain_flags[TableDepth];
  assign fin_vld = chain_vld[TableDepth] && (state == S_SCAN);

  always_comb begin
    status_next = ST_OK;
    wr_cmd      = '0;
    wr_idx      = chain_hit_idx[TableDepth];
    case (req_kind)
      REQ_ADD: begin
        if (fin.hit) begin
          status_next = fin.hit_same ? ST_EXISTS : ST_DENIED;
        end else if (fin.free_found) begin
          wr_cmd.set = fin_vld;
          wr_idx     = chain_free_idx[TableDepth];
        end else begin
          status_next = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (!fin.hit) begin
          status_next = ST_NOT_FOUND;
        end else if (!fin.hit_same) begin
          status_next = ST_DENIED;
        end else begin
          wr_cmd.clr = fin_vld;
        end
      end
      REQ_CHECK: begin
        if (fin.hit && !fin.hit_open && !fin.hit_same) begin
          status_next = ST_DENIED;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state  <= S_SCAN;
            busy   <= 1'b1;
            launch <= 1'b1;
          end
        end
        S_SCAN: begin
          if (fin_vld) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_kind  <= req_type;
      req_upper <= key_upper;
      req_lower <= key_lower;
      req_owner <= requester;
    end
    if (fin_vld) begin
      status <= status_next;
    end
  end

  `OAT_ASSERT_ALW(a_one_token, clk, rst, $onehot0(vld_vec))
  `OAT_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  `OAT_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && launch)
  `OAT_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `OAT_ASSERT_IMP(a_write_one_kind, clk, rst, wr_cmd.set || wr_cmd.clr, !(wr_cmd.set && wr_cmd.clr))

endmodule
